// ===== sv/mls_pkg.sv =====
// Shared widths, types and Morse lookup functions for the lamp sequencer.
// Used by every module of the block; no dependencies of its own.
`timescale 1ns / 1ps
`default_nettype none
package mls_pkg;

  // Text store capacity and derived widths.
  localparam int MAX_TEXT = 256;
  localparam int ADDR_W   = $clog2(MAX_TEXT);
  localparam int LEN_W    = $clog2(MAX_TEXT + 1);

  // Result queue depth and derived widths.
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Characters with a special meaning in the text.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_STAR  = 8'h2A;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [LEN_W-1:0]  len_t;

  // One lamp update on its way to the result queue.
  typedef struct packed {
    logic valid;
    logic lamp;
    logic last;
  } res_t;

  // Lower-case letters become capitals; everything else passes unchanged.
  function automatic logic [7:0] fold_char(input logic [7:0] c);
    if (c >= 8'h61 && c <= 8'h7A) begin
      return c - 8'h20;
    end
    return c;
  endfunction

  // True for A..Z and 0..9 (after folding).
  function automatic logic is_code_char(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h30 && c <= 8'h39);
  endfunction

  // Index into the Morse table: letters 0..25, digits 26..35.
  function automatic logic [5:0] char_slot(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= 8'h41 && c <= 8'h5A) begin
      d = c - 8'h41;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30 + 8'd26;
    end
    return d[5:0];
  endfunction

  // Morse code of one slot: {length[2:0], pattern[4:0]}, pattern bit i set
  // when element i is a dash.
  function automatic logic [7:0] code_entry(input logic [5:0] slot);
    logic [7:0] e;
    case (slot)
      6'd0:  e = {3'd2, 5'b00010};
      6'd1:  e = {3'd4, 5'b00001};
      6'd2:  e = {3'd4, 5'b00101};
      6'd3:  e = {3'd3, 5'b00001};
      6'd4:  e = {3'd1, 5'b00000};
      6'd5:  e = {3'd4, 5'b00100};
      6'd6:  e = {3'd3, 5'b00011};
      6'd7:  e = {3'd4, 5'b00000};
      6'd8:  e = {3'd2, 5'b00000};
      6'd9:  e = {3'd4, 5'b01110};
      6'd10: e = {3'd3, 5'b00101};
      6'd11: e = {3'd4, 5'b00010};
      6'd12: e = {3'd2, 5'b00011};
      6'd13: e = {3'd2, 5'b00001};
      6'd14: e = {3'd3, 5'b00111};
      6'd15: e = {3'd4, 5'b00110};
      6'd16: e = {3'd4, 5'b01011};
      6'd17: e = {3'd3, 5'b00010};
      6'd18: e = {3'd3, 5'b00000};
      6'd19: e = {3'd1, 5'b00001};
      6'd20: e = {3'd3, 5'b00100};
      6'd21: e = {3'd4, 5'b01000};
      6'd22: e = {3'd3, 5'b00110};
      6'd23: e = {3'd4, 5'b01001};
      6'd24: e = {3'd4, 5'b01101};
      6'd25: e = {3'd4, 5'b00011};
      6'd26: e = {3'd5, 5'b11111};
      6'd27: e = {3'd5, 5'b11110};
      6'd28: e = {3'd5, 5'b11100};
      6'd29: e = {3'd5, 5'b11000};
      6'd30: e = {3'd5, 5'b10000};
      6'd31: e = {3'd5, 5'b00000};
      6'd32: e = {3'd5, 5'b00001};
      6'd33: e = {3'd5, 5'b00011};
      6'd34: e = {3'd5, 5'b00111};
      6'd35: e = {3'd5, 5'b01111};
      default: e = 8'h00;
    endcase
    return e;
  endfunction

  // Element e of character c is a dash (false past the end of the code).
  function automatic logic elem_is_dash(input logic [7:0] c, input logic [2:0] e);
    logic [7:0] ent;
    logic [7:0] pat;
    ent = code_entry(char_slot(c));
    pat = {3'b000, ent[4:0]};
    return is_code_char(c) && (e < ent[7:5]) && pat[e];
  endfunction

  // Number of elements of character c (zero for non-code characters).
  function automatic logic [2:0] code_len(input logic [7:0] c);
    logic [7:0] ent;
    ent = code_entry(char_slot(c));
    return is_code_char(c) ? ent[7:5] : 3'd0;
  endfunction

endpackage
`default_nettype wire

// ===== sv/morse_lamp_sequencer_unit.sv =====
// Top level of the Morse lamp sequencer: text loading, playback sequencing.
// Depends on mls_pkg, mls_text_ram and mls_out_fifo.
//
//  Channel  Dir  Transfer fields
//  s_axis   in   tuser = opcode (0 tick, 1 char), tdata = text_char, tlast = final_char
//  m_axis   out  tdata[0] = lamp_on (bits 7:1 zero), tlast = last_result
//
// Each input item has an accept cycle and an update cycle: the accept cycle issues the
// text store read of the following character, and the next cycle updates the playback
// state and queues 0, 1 or 2 lamp updates. s_axis_tready is low in that update cycle and
// while fewer than two result slots are free. Results wait in a 4-entry queue, so input
// keeps flowing while the output stalls as long as two slots are free. Reset clears all
// control state; the text store is not cleared, only entries below text length are used.
`timescale 1ns / 1ps
`default_nettype none
module morse_lamp_sequencer_unit
  import mls_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] text_char
  input  wire logic       s_axis_tuser,   // [0] opcode
  input  wire logic       s_axis_tlast,
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic      [7:0] m_axis_tdata,   // [0] lamp_on, [7:1] zero
  output logic            m_axis_tlast
);

  // Playback phase codes.
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_START = 3'd1;
  localparam logic [2:0] PH_ON    = 3'd2;
  localparam logic [2:0] PH_AFTER = 3'd3;
  localparam logic [2:0] PH_PAUSE = 3'd4;

  localparam logic OP_TICK = 1'b0;

  // Control state.
  logic [2:0] phase, phase_next;
  logic [2:0] units, units_next;
  logic [2:0] elem, elem_next;
  len_t       cp, cp_next;
  len_t       len, len_next;
  logic       loading, loading_next;
  logic       busy;

  // Character registers: character at the play position and at position 0.
  logic [7:0] cur_char, cur_char_next;
  logic [7:0] first_char, first_char_next;

  // Item held for its update cycle.
  logic       it_op;
  logic [7:0] it_char;
  logic       it_fin;

  // Text store ports.
  logic       accept;
  logic       st_we;
  addr_t      st_waddr;
  logic [7:0] st_wdata;
  len_t       cp_inc;
  logic [7:0] rd_char;

  // Result queue.
  res_t       push0, push1;
  logic       room2;
  logic       q_lamp;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !busy && room2;
  assign cp_inc        = cp + len_t'(1);
  assign m_axis_tdata  = {7'b0000000, q_lamp};

  mls_text_ram u_text_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (accept),
    .raddr (cp_inc[ADDR_W-1:0]),
    .rdata (rd_char)
  );

  mls_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push0     (push0),
    .push1     (push1),
    .room2     (room2),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_lamp  (q_lamp),
    .out_last  (m_axis_tlast)
  );

  // Update cycle: load a character or run one Morse unit of playback.
  always_comb begin
    logic [7:0] fc;
    logic       keep;
    len_t       len_base;
    logic [2:0] t_phase;
    logic [2:0] t_units;
    logic [2:0] t_elem;
    len_t       t_cp;
    len_t       t_len;
    logic [7:0] t_cur;
    logic [7:0] t_first;
    logic [7:0] cur_eff;
    logic       run;
    logic       do_begin;
    len_t       b_pos;
    logic [7:0] b_char;
    logic       do_start;
    logic [7:0] s_char;
    logic [2:0] s_elem;
    logic [2:0] e_inc;
    logic       emit;
    logic       emit_lamp;

    phase_next      = phase;
    units_next      = units;
    elem_next       = elem;
    cp_next         = cp;
    len_next        = len;
    loading_next    = loading;
    cur_char_next   = cur_char;
    first_char_next = first_char;
    st_we           = 1'b0;
    st_waddr        = '0;
    st_wdata        = 8'h00;
    push0           = '0;
    push1           = '0;

    fc       = fold_char(it_char);
    len_base = loading ? len : '0;
    keep     = (is_code_char(fc) || fc == CH_SPACE || fc == CH_STAR)
               && (len_base < len_t'(MAX_TEXT));

    t_phase  = phase;
    t_units  = units;
    t_elem   = elem;
    t_cp     = cp;
    t_len    = len;
    t_cur    = cur_char;
    t_first  = first_char;
    run      = 1'b0;
    do_begin = 1'b0;
    b_pos    = '0;
    b_char   = 8'h00;
    do_start = 1'b0;
    s_char   = 8'h00;
    s_elem   = 3'd0;
    emit     = 1'b0;
    emit_lamp = 1'b0;

    if (busy) begin
      if (it_op == OP_TICK) begin
        run = !loading;
      end else begin
        // Store the folded character; the first one of a string halts play.
        st_waddr = len_base[ADDR_W-1:0];
        st_wdata = fc;
        st_we    = keep;
        len_next = len_base + len_t'(keep);
        if (keep && len_base == '0) begin
          first_char_next = fc;
        end
        if (!loading) begin
          phase_next = PH_IDLE;
        end
        loading_next = !it_fin;
        if (it_fin) begin
          // Restart from the first character and run one unit at once.
          t_phase = PH_START;
          t_units = 3'd0;
          t_elem  = 3'd0;
          t_cp    = '0;
          t_len   = len_next;
          t_first = first_char_next;
          t_cur   = first_char_next;
          phase_next = PH_START;
          units_next = 3'd0;
          elem_next  = 3'd0;
          cp_next    = '0;
          run        = 1'b1;
        end
      end
    end

    cur_eff = (t_cp < t_len) ? t_cur : 8'h00;
    e_inc   = t_elem + 3'd1;

    // One Morse unit of the playback sequencer.
    if (run) begin
      case (t_phase)
        PH_START: begin
          do_begin = 1'b1;
          b_pos    = t_cp;
          b_char   = cur_eff;
        end
        PH_ON: begin
          if (t_units != 3'd0) begin
            units_next = t_units - 3'd1;
          end else begin
            phase_next = PH_AFTER;
            emit       = 1'b1;
            emit_lamp  = 1'b0;
          end
        end
        PH_AFTER: begin
          elem_next = e_inc;
          if (e_inc < code_len(cur_eff)) begin
            do_start = 1'b1;
            s_char   = cur_eff;
            s_elem   = e_inc;
          end else begin
            phase_next = PH_PAUSE;
            units_next = 3'd1;
          end
        end
        PH_PAUSE: begin
          if (t_units != 3'd0) begin
            units_next = t_units - 3'd1;
          end else begin
            do_begin = 1'b1;
            b_pos    = (cur_eff == CH_STAR) ? len_t'(0) : t_cp + len_t'(1);
            b_char   = (b_pos == '0) ? t_first : rd_char;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end

    // Begin the character at a new play position.
    if (do_begin) begin
      cp_next       = b_pos;
      cur_char_next = b_char;
      if (b_pos >= t_len) begin
        phase_next = PH_IDLE;
      end else if (b_char == CH_SPACE || b_char == CH_STAR) begin
        phase_next = PH_PAUSE;
        units_next = 3'd4;
      end else begin
        elem_next = 3'd0;
        do_start  = 1'b1;
        s_char    = b_char;
        s_elem    = 3'd0;
      end
    end

    // Start a dot or a dash: lamp on, with two extra on units for a dash.
    if (do_start) begin
      units_next = elem_is_dash(s_char, s_elem) ? 3'd2 : 3'd0;
      phase_next = PH_ON;
      emit       = 1'b1;
      emit_lamp  = 1'b1;
    end

    // Queue the lamp updates; a final character first turns the lamp off.
    if (busy && it_op != OP_TICK && it_fin) begin
      push0 = '{valid: 1'b1, lamp: 1'b0, last: !emit};
      push1 = '{valid: emit, lamp: emit_lamp, last: 1'b1};
    end else begin
      push0 = '{valid: emit, lamp: emit_lamp, last: 1'b1};
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      units   <= 3'd0;
      elem    <= 3'd0;
      cp      <= '0;
      len     <= '0;
      loading <= 1'b0;
      busy    <= 1'b0;
    end else begin
      phase   <= phase_next;
      units   <= units_next;
      elem    <= elem_next;
      cp      <= cp_next;
      len     <= len_next;
      loading <= loading_next;
      busy    <= accept;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cur_char   <= cur_char_next;
    first_char <= first_char_next;
    if (accept) begin
      it_op   <= s_axis_tuser;
      it_char <= s_axis_tdata;
      it_fin  <= s_axis_tlast;
    end
  end

endmodule
`default_nettype wire

// ===== sv/mls_text_ram.sv =====
// Text store: one write port and one registered read port.
// Depends on mls_pkg for the depth and address width.
`timescale 1ns / 1ps
`default_nettype none
module mls_text_ram
  import mls_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       we,
  input  wire addr_t      waddr,
  input  wire logic [7:0] wdata,
  input  wire logic       re,
  input  wire addr_t      raddr,
  output logic      [7:0] rdata
);

  logic [7:0] mem [MAX_TEXT];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, updated only when re is set.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/mls_out_fifo.sv =====
// Small result queue that takes up to two lamp updates per cycle.
// Depends on mls_pkg for the depth and the result struct.
`timescale 1ns / 1ps
`default_nettype none
module mls_out_fifo
  import mls_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire res_t push0,
  input  wire res_t push1,
  output logic      room2,
  output logic      out_valid,
  input  wire logic out_ready,
  output logic      out_lamp,
  output logic      out_last
);

  logic [1:0]       entry [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [PTR_W-1:0] wr_ptr_next;
  logic [PTR_W-1:0] wr_ptr_1;
  logic             pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign out_lamp  = entry[rd_ptr][1];
  assign out_last  = entry[rd_ptr][0];
  assign room2     = (count <= CNT_W'(FIFO_DEPTH - 2));
  assign wr_ptr_1  = wr_ptr + PTR_W'(1);

  // Pointer and fill count arithmetic for the current cycle.
  always_comb begin
    wr_ptr_next = wr_ptr + PTR_W'(push0.valid) + PTR_W'(push1.valid);
    count_next  = count + CNT_W'(push0.valid) + CNT_W'(push1.valid) - CNT_W'(pop);
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
    end
  end

  // Entry storage; the second update always follows the first.
  always_ff @(posedge clk) begin
    if (push0.valid) begin
      entry[wr_ptr] <= {push0.lamp, push0.last};
    end
    if (push1.valid) begin
      entry[wr_ptr_1] <= {push1.lamp, push1.last};
    end
  end

endmodule
`default_nettype wire

// ===== verif/morse_lamp_sequencer_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for morse_lamp_sequencer_unit: a directed stimulus table whose
// typed rows carry their own expected updates, then random text strings and ticks checked
// by a Morse keyer predictor kept here. Depends on mls_pkg and the sequencer RTL; reads no files.
module morse_lamp_sequencer_unit_tb;
  import mls_pkg::*;

  localparam int N_ITEMS = 1050;
  localparam int LONG_CHARS = MAX_TEXT + 14;
  localparam int TAIL_CYCLES = 20;

  // Input opcodes.
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_CHAR = 1'b1;

  // Characters used by the directed table and the predictor.
  localparam logic [7:0] CH_DASH = 8'h2D;
  localparam logic [7:0] CH_HASH = 8'h23;

  typedef enum logic [2:0] {
    PLAY_IDLE,
    PLAY_START,
    PLAY_ON,
    PLAY_AFTER,
    PLAY_PAUSE
  } play_phase_e;

  // One lamp update as seen on the output stream.
  typedef struct packed {
    logic lamp;
    logic last_res;
  } lamp_res_t;

  // One row of the directed table; typed rows carry their own expected updates.
  typedef struct packed {
    logic       op;
    logic [7:0] ch;
    logic       fin;
    logic       typed;
    logic [1:0] n_typed;
    lamp_res_t  res0;
    lamp_res_t  res1;
  } stim_row_t;

  logic       clk;
  logic       rst;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic       s_axis_tuser;
  logic       s_axis_tlast;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;

  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int item_count = 0;

  stim_row_t directed_rows [$];
  lamp_res_t expected_lamp_q [$];
  lamp_res_t step_out [$];

  // Keyer state mirrored by the predictor.
  logic [7:0]  text_mem [MAX_TEXT];
  len_t        text_len = '0;
  len_t        char_pos = '0;
  logic [2:0]  elem_pos = '0;
  logic [2:0]  units_left = '0;
  play_phase_e play_phase = PLAY_IDLE;
  logic        loading = 1'b0;

  // Morse codes of A..Z, then 0..9.
  string morse_code [36] = '{
    ".-", "-...", "-.-.", "-..", ".", "..-.", "--.",
    "....", "..", ".---", "-.-", ".-..", "--", "-.",
    "---", ".--.", "--.-", ".-.", "...", "-", "..-",
    "...-", ".--", "-..-", "-.--", "--..",
    "-----", ".----", "..---", "...--", "....-",
    ".....", "-....", "--...", "---..", "----."
  };

  morse_lamp_sequencer_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] text_char
    .s_axis_tuser  (s_axis_tuser),   // [0] opcode
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [0] lamp_on, [7:1] zero
    .m_axis_tlast  (m_axis_tlast)
  );

  // Clock with a 12 ns period.
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Table slot of a folded character, or -1 when it has no Morse code.
  function automatic int slot_of(input logic [7:0] c);
    if (c >= "A" && c <= "Z") begin
      return int'(c) - int'("A");
    end
    if (c >= "0" && c <= "9") begin
      return 26 + int'(c) - int'("0");
    end
    return -1;
  endfunction

  function automatic int elem_count(input logic [7:0] c);
    int k;
    k = slot_of(c);
    return (k < 0) ? 0 : morse_code[k].len();
  endfunction

  function automatic logic [7:0] playing_char();
    return (char_pos < text_len) ? text_mem[char_pos[ADDR_W-1:0]] : 8'h00;
  endfunction

  function automatic void keyer_emit(input logic lamp);
    lamp_res_t r;
    r.lamp = lamp;
    r.last_res = 1'b0;
    step_out.push_back(r);
  endfunction

  // Lamp on for the current element; a dash holds it for two more units.
  function automatic void keyer_start_element();
    int   k;
    logic dash;
    k = slot_of(playing_char());
    dash = 1'b0;
    if (k >= 0 && elem_pos < morse_code[k].len()) begin
      dash = (morse_code[k][elem_pos] == CH_DASH);
    end
    units_left = dash ? 3'd2 : 3'd0;
    play_phase = PLAY_ON;
    keyer_emit(1'b1);
  endfunction

  function automatic void keyer_begin_char();
    logic [7:0] c;
    if (char_pos >= text_len) begin
      play_phase = PLAY_IDLE;
      return;
    end
    c = playing_char();
    if (c == CH_SPACE || c == CH_STAR) begin
      play_phase = PLAY_PAUSE;
      units_left = 3'd4;
    end else begin
      elem_pos = 3'd0;
      keyer_start_element();
    end
  endfunction

  // One Morse time unit of playback.
  function automatic void keyer_tick();
    case (play_phase)
      PLAY_START: keyer_begin_char();
      PLAY_ON: begin
        if (units_left != 3'd0) begin
          units_left = units_left - 3'd1;
        end else begin
          play_phase = PLAY_AFTER;
          keyer_emit(1'b0);
        end
      end
      PLAY_AFTER: begin
        elem_pos = elem_pos + 3'd1;
        if (elem_pos < elem_count(playing_char())) begin
          keyer_start_element();
        end else begin
          play_phase = PLAY_PAUSE;
          units_left = 3'd1;
        end
      end
      PLAY_PAUSE: begin
        if (units_left != 3'd0) begin
          units_left = units_left - 3'd1;
        end else begin
          if (playing_char() == CH_STAR) begin
            char_pos = '0;
          end else begin
            char_pos = char_pos + len_t'(1);
          end
          keyer_begin_char();
        end
      end
      default: play_phase = PLAY_IDLE;
    endcase
  endfunction

  // Lamp updates caused by one accepted input transfer, left in step_out.
  function automatic void keyer_step(input logic op, input logic [7:0] ch, input logic fin);
    logic [7:0] c;
    lamp_res_t  r;
    step_out.delete();
    if (op == OP_TICK) begin
      if (!loading) begin
        keyer_tick();
      end
    end else begin
      // The first character of a string stops playback and empties the store.
      if (!loading) begin
        loading = 1'b1;
        text_len = '0;
        play_phase = PLAY_IDLE;
      end
      c = ch;
      if (c >= "a" && c <= "z") begin
        c = c - 8'h20;
      end
      if ((slot_of(c) >= 0 || c == CH_SPACE || c == CH_STAR) && text_len < MAX_TEXT) begin
        text_mem[text_len[ADDR_W-1:0]] = c;
        text_len = text_len + len_t'(1);
      end
      // The final character switches the lamp off and starts play at once.
      if (fin) begin
        loading = 1'b0;
        char_pos = '0;
        elem_pos = 3'd0;
        units_left = 3'd0;
        play_phase = PLAY_START;
        keyer_emit(1'b0);
        keyer_tick();
      end
    end
    if (step_out.size() > 0) begin
      r = step_out.pop_back();
      r.last_res = 1'b1;
      step_out.push_back(r);
    end
  endfunction

  function automatic void add_row(input logic op, input logic [7:0] ch, input logic fin,
                                  input logic typed, input logic [1:0] n_typed,
                                  input lamp_res_t res0, input lamp_res_t res1);
    stim_row_t row;
    row.op = op;
    row.ch = ch;
    row.fin = fin;
    row.typed = typed;
    row.n_typed = n_typed;
    row.res0 = res0;
    row.res1 = res1;
    directed_rows.push_back(row);
  endfunction

  // Mostly letters, digits, spaces and stars, in both cases.
  function automatic logic [7:0] rand_text_char();
    int r;
    r = $urandom_range(99);
    if (r < 40) return 8'("A" + $urandom_range(25));
    if (r < 60) return 8'("a" + $urandom_range(25));
    if (r < 80) return 8'("0" + $urandom_range(9));
    if (r < 90) return CH_SPACE;
    return CH_STAR;
  endfunction

  // Present one input transfer and return at the edge where it is accepted.
  task automatic send_item(input logic op, input logic [7:0] ch, input logic fin);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= fin;
    @(posedge clk);
    while (!s_axis_tready) begin
      @(posedge clk);
    end
  endtask

  task automatic transfer_and_predict(input logic op, input logic [7:0] ch, input logic fin);
    send_item(op, ch, fin);
    keyer_step(op, ch, fin);
    foreach (step_out[i]) begin
      expected_lamp_q.push_back(step_out[i]);
    end
    item_count++;
  endtask

  // Output side: random stalls at the current rate.
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare every output transfer with the oldest expected lamp update.
  always @(posedge clk) begin
    lamp_res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_lamp_q.size() == 0) begin
        $error("unexpected lamp update: lamp_on=%0d last_result=%0d",
               m_axis_tdata[0], m_axis_tlast);
        mismatch_count++;
      end else begin
        want = expected_lamp_q.pop_front();
        if (m_axis_tdata[0] !== want.lamp) begin
          $error("lamp_on: expected %0d, got %0d", want.lamp, m_axis_tdata[0]);
          mismatch_count++;
        end
        if (m_axis_tlast !== want.last_res) begin
          $error("last_result: expected %0d, got %0d", want.last_res, m_axis_tlast);
          mismatch_count++;
        end
        if (m_axis_tdata[7:1] !== 7'd0) begin
          $error("tdata padding: expected 0, got %0h", m_axis_tdata[7:1]);
          mismatch_count++;
        end
      end
    end
  end

  // Main stimulus: reset, directed table, random strings, drain.
  initial begin
    stim_row_t   row;
    lamp_res_t   no_res;
    lamp_res_t   off_mid;
    lamp_res_t   on_last;
    lamp_res_t   off_last;
    int          n_chars;
    int          n_ticks;
    logic [7:0]  c;
    logic        long_done;

    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tuser = OP_TICK;
    s_axis_tdata = 8'h00;
    s_axis_tlast = 1'b0;
    long_done = 1'b0;
    no_res = '0;
    off_mid = '{lamp: 1'b0, last_res: 1'b0};
    on_last = '{lamp: 1'b1, last_res: 1'b1};
    off_last = '{lamp: 1'b0, last_res: 1'b1};

    // Tick straight after reset does nothing.
    add_row(OP_TICK, 8'h00, 1'b0, 1'b1, 2'd0, no_res, no_res);
    // One lower-case letter as a whole string: lamp off, then on for the dot.
    add_row(OP_CHAR, "e", 1'b1, 1'b1, 2'd2, off_mid, on_last);
    // Play it out; the tick ignores the char and last fields.
    add_row(OP_TICK, 8'hFF, 1'b1, 1'b0, 2'd0, no_res, no_res);
    add_row(OP_TICK, 8'h00, 1'b0, 1'b0, 2'd0, no_res, no_res);
    add_row(OP_TICK, 8'h00, 1'b0, 1'b0, 2'd0, no_res, no_res);
    add_row(OP_TICK, 8'h00, 1'b0, 1'b0, 2'd0, no_res, no_res);
    // A longer string with unknown characters, a tick while loading, and a trailing star.
    add_row(OP_CHAR, "a", 1'b0, 1'b1, 2'd0, no_res, no_res);
    add_row(OP_TICK, 8'h00, 1'b0, 1'b1, 2'd0, no_res, no_res);
    add_row(OP_CHAR, 8'hFF, 1'b0, 1'b1, 2'd0, no_res, no_res);
    add_row(OP_CHAR, 8'h00, 1'b0, 1'b1, 2'd0, no_res, no_res);
    add_row(OP_CHAR, "0", 1'b0, 1'b1, 2'd0, no_res, no_res);
    add_row(OP_CHAR, CH_SPACE, 1'b0, 1'b1, 2'd0, no_res, no_res);
    add_row(OP_CHAR, "9", 1'b0, 1'b1, 2'd0, no_res, no_res);
    add_row(OP_CHAR, "Z", 1'b0, 1'b1, 2'd0, no_res, no_res);
    add_row(OP_CHAR, "z", 1'b0, 1'b1, 2'd0, no_res, no_res);
    add_row(OP_CHAR, CH_STAR, 1'b1, 1'b0, 2'd0, no_res, no_res);
    for (int i = 0; i < 8; i++) begin
      add_row(OP_TICK, 8'(i * 37), 1'(i), 1'b0, 2'd0, no_res, no_res);
    end
    // A new string halts play; an empty one only switches the lamp off.
    add_row(OP_CHAR, CH_HASH, 1'b1, 1'b1, 2'd1, off_last, no_res);
    add_row(OP_TICK, 8'h00, 1'b0, 1'b0, 2'd0, no_res, no_res);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed table, no idling on either side.
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_item(row.op, row.ch, row.fin);
      keyer_step(row.op, row.ch, row.fin);
      if (row.typed) begin
        if (row.n_typed > 0) expected_lamp_q.push_back(row.res0);
        if (row.n_typed > 1) expected_lamp_q.push_back(row.res1);
      end else begin
        foreach (step_out[j]) begin
          expected_lamp_q.push_back(step_out[j]);
        end
      end
    end

    // Random part: mostly whole strings followed by ticks, some noise.
    item_count = 0;
    while (item_count < N_ITEMS) begin
      case ((item_count / 100) % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin sender_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      if (!long_done && item_count >= 500) begin
        // Overfill the store once; characters past its capacity are dropped.
        long_done = 1'b1;
        for (int i = 0; i < LONG_CHARS; i++) begin
          transfer_and_predict(OP_CHAR, rand_text_char(), i == LONG_CHARS - 1);
        end
        n_ticks = 150;
      end else if ($urandom_range(99) < 80) begin
        n_chars = $urandom_range(1, 10);
        for (int i = 0; i < n_chars; i++) begin
          c = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : rand_text_char();
          transfer_and_predict(OP_CHAR, c, i == n_chars - 1);
        end
        n_ticks = $urandom_range(4, 80);
      end else begin
        transfer_and_predict(1'($urandom_range(1)), 8'($urandom_range(255)),
                             1'($urandom_range(1)));
        n_ticks = $urandom_range(0, 3);
      end
      for (int i = 0; i < n_ticks; i++) begin
        transfer_and_predict(OP_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end
    end
    s_axis_tvalid <= 1'b0;

    // Drain the expected queue, then wait out the tail for anything stray.
    while (expected_lamp_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== files.f =====
sv/mls_pkg.sv
sv/mls_text_ram.sv
sv/mls_out_fifo.sv
sv/morse_lamp_sequencer_unit.sv
verif/morse_lamp_sequencer_unit_tb.sv
